@@ design/tiled_rgb_run_length_decoder_macros.svh @@
// ----------------------------------------------------------------------------
// Tiled RGB run-length decoder assertion macros
// Concurrent assertion forms for the decoder's top level.
// ----------------------------------------------------------------------------
`ifndef TILED_RGB_RUN_LENGTH_DECODER_MACROS_SVH
`define TILED_RGB_RUN_LENGTH_DECODER_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define TRLD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define TRLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define TRLD_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/trld_pkg.sv @@
// ----------------------------------------------------------------------------
// Tiled RGB run-length decoder package
// Constants, register indices and controller/datapath interface types.
// ----------------------------------------------------------------------------
package trld_pkg;

    localparam int DEF_MAX_BLOCK = 8;
    localparam int DEF_MAX_RUN   = 64;
    localparam int MAX_DIMENSION = 4096;

    localparam int DIM_W     = 13;  // width and height registers
    localparam int BLK_W     = 4;   // block size register
    localparam int ORG_W     = 14;  // tile origins and absolute row/column
    localparam int ADDR_W    = 24;  // raster address
    localparam int COLOUR_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W = 8;
    localparam int OUT_DATA_W = ADDR_W + 3 * COLOUR_W;
    localparam int OUT_USER_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd2;

    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 13'd64;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 13'd64;
    localparam logic [BLK_W-1:0] RST_BLOCK_SIZE   = 4'd8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap_blue;
        logic cap_green;
        logic cap_red;
        logic start_run;
        logic zero_emit;
        logic step;
        logic flush;
    } trld_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic byte_zero;
        logic walk_end;
        logic pend_valid;
        logic out_free;
    } trld_sts_t;

endpackage

@@ design/trld_ctrl.sv @@
// ----------------------------------------------------------------------------
// Tiled RGB run-length decoder controller
// Tracks the byte phase and sequences each run through the datapath.
// ----------------------------------------------------------------------------
module trld_ctrl
    import trld_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  trld_sts_t sts,
    output trld_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ZERO,
        ST_WALK,
        ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        PH_BLUE,
        PH_GREEN,
        PH_RED,
        PH_LENGTH
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   take;

    assign s_ready = (state_reg == ST_IDLE);
    assign take    = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    unique case (phase_reg)
                        PH_BLUE: begin
                            cmd.cap_blue = 1'b1;
                            phase_next   = PH_GREEN;
                        end
                        PH_GREEN: begin
                            cmd.cap_green = 1'b1;
                            phase_next    = PH_RED;
                        end
                        PH_RED: begin
                            cmd.cap_red = 1'b1;
                            phase_next  = PH_LENGTH;
                        end
                        PH_LENGTH: begin
                            phase_next = PH_BLUE;
                            if (sts.byte_zero) begin
                                state_next = ST_ZERO;
                            end else begin
                                cmd.start_run = 1'b1;
                                state_next    = ST_WALK;
                            end
                        end
                        default: phase_next = PH_BLUE;
                    endcase
                end
            end
            ST_ZERO: begin
                if (sts.out_free) begin
                    cmd.zero_emit = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_WALK: begin
                if (sts.out_free) begin
                    cmd.step = 1'b1;
                    if (sts.walk_end) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (sts.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_BLUE;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

@@ design/trld_datapath.sv @@
// ----------------------------------------------------------------------------
// Tiled RGB run-length decoder datapath
// Configuration, tile cursor, address arithmetic, pending and output stages.
// ----------------------------------------------------------------------------
module trld_datapath
    import trld_pkg::*;
#(
    parameter int MAX_BLOCK = DEF_MAX_BLOCK,
    parameter int MAX_RUN   = DEF_MAX_RUN
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic [IN_DATA_W-1:0] in_byte,
    input  trld_cmd_t            cmd,
    output trld_sts_t            sts,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic [ADDR_W-1:0]    m_addr,
    output logic [COLOUR_W-1:0]  m_blue,
    output logic [COLOUR_W-1:0]  m_green,
    output logic [COLOUR_W-1:0]  m_red,
    output logic                 m_last,
    output logic                 m_err,
    output logic                 m_done
);

    localparam int TILE_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int RUN_W  = $clog2(MAX_RUN + 1);
    localparam int PROD_W = ORG_W + DIM_W;

    localparam logic [IN_DATA_W-1:0] RUN_LIMIT = IN_DATA_W'(MAX_RUN);
    localparam logic [BLK_W-1:0]     BLK_LIMIT = BLK_W'(MAX_BLOCK);
    localparam logic [DIM_W-1:0]     DIM_LIMIT = DIM_W'(MAX_DIMENSION);

    // Configuration registers.
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [BLK_W-1:0] block_reg;

    // Run state.
    logic [COLOUR_W-1:0] blue_reg, green_reg, red_reg;
    logic [RUN_W-1:0]    count_reg;
    logic                run_err_reg;

    // Tile cursor.
    logic [ORG_W-1:0]  row_org_reg, col_org_reg;
    logic [TILE_W-1:0] row_in_reg, col_in_reg;
    logic              filled_reg;

    // Pending result, held until it is known whether it closes the run.
    logic              pend_valid_reg;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic              pend_done_reg;

    // Output register.
    logic                m_valid_reg;
    logic [ADDR_W-1:0]   m_addr_reg;
    logic [COLOUR_W-1:0] m_blue_reg, m_green_reg, m_red_reg;
    logic                m_last_reg, m_err_reg, m_done_reg;

    logic [DIM_W-1:0]  w_eff, h_eff;
    logic [BLK_W-1:0]  bs_eff;
    logic [ORG_W-1:0]  w_ext, h_ext, r_pos, c_pos;
    logic [PROD_W-1:0] prod, addr_full;
    logic [ADDR_W-1:0] addr_calc;
    logic              outside, emit_pos, done_pos, out_free, emit_now;
    logic [BLK_W-1:0]  col_inc, row_inc;
    logic [ORG_W-1:0]  col_org_inc, row_org_inc;
    logic [RUN_W-1:0]  run_len;

    // Clamp the registers into their working ranges.
    always_comb begin
        if (width_reg == '0)           w_eff = DIM_W'(1);
        else if (width_reg > DIM_LIMIT) w_eff = DIM_LIMIT;
        else                            w_eff = width_reg;
        if (height_reg == '0)           h_eff = DIM_W'(1);
        else if (height_reg > DIM_LIMIT) h_eff = DIM_LIMIT;
        else                             h_eff = height_reg;
        if (block_reg == '0)            bs_eff = BLK_W'(1);
        else if (block_reg > BLK_LIMIT) bs_eff = BLK_LIMIT;
        else                            bs_eff = block_reg;
    end

    assign w_ext = ORG_W'(w_eff);
    assign h_ext = ORG_W'(h_eff);
    assign r_pos = row_org_reg + ORG_W'(row_in_reg);
    assign c_pos = col_org_reg + ORG_W'(col_in_reg);

    assign prod      = PROD_W'(r_pos) * PROD_W'(w_eff);
    assign addr_full = prod + PROD_W'(c_pos);
    assign addr_calc = addr_full[ADDR_W-1:0];

    assign outside  = (r_pos >= h_ext);
    assign emit_pos = !filled_reg && !outside && (c_pos < w_ext);
    assign done_pos = emit_pos && (r_pos == h_ext - ORG_W'(1))
                      && (c_pos == w_ext - ORG_W'(1));

    assign col_inc     = BLK_W'(col_in_reg) + BLK_W'(1);
    assign row_inc     = BLK_W'(row_in_reg) + BLK_W'(1);
    assign col_org_inc = col_org_reg + ORG_W'(bs_eff);
    assign row_org_inc = row_org_reg + ORG_W'(bs_eff);

    assign run_len  = (in_byte > RUN_LIMIT) ? RUN_W'(MAX_RUN) : RUN_W'(in_byte);
    assign out_free = !m_valid_reg || m_ready;
    assign emit_now = cmd.step && emit_pos;

    assign sts.byte_zero  = (in_byte == '0);
    assign sts.walk_end   = filled_reg || outside || done_pos || (count_reg == RUN_W'(1));
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = out_free;

    // Configuration and colour capture.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_IMAGE_WIDTH;
            height_reg <= RST_IMAGE_HEIGHT;
            block_reg  <= RST_BLOCK_SIZE;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                REG_BLOCK_SIZE:   block_reg  <= cfg_data[BLK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_blue)  blue_reg  <= in_byte;
        if (cmd.cap_green) green_reg <= in_byte;
        if (cmd.cap_red)   red_reg   <= in_byte;
        if (cmd.start_run) begin
            run_err_reg <= (in_byte > RUN_LIMIT);
        end
    end

    // Run counter and tile cursor.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            row_org_reg <= '0;
            col_org_reg <= '0;
            row_in_reg  <= '0;
            col_in_reg  <= '0;
            filled_reg  <= 1'b0;
        end else if (cmd.start_run) begin
            count_reg <= run_len;
        end else if (cmd.step) begin
            count_reg <= count_reg - RUN_W'(1);
            if (!filled_reg) begin
                if (outside) begin
                    filled_reg <= 1'b1;
                end else begin
                    if (done_pos) filled_reg <= 1'b1;
                    if (col_inc >= bs_eff) begin
                        col_in_reg <= '0;
                        if (row_inc >= bs_eff) begin
                            row_in_reg <= '0;
                            if (col_org_inc >= w_ext) begin
                                col_org_reg <= '0;
                                row_org_reg <= row_org_inc;
                                if (row_org_inc >= h_ext) filled_reg <= 1'b1;
                            end else begin
                                col_org_reg <= col_org_inc;
                            end
                        end else begin
                            row_in_reg <= TILE_W'(row_inc);
                        end
                    end else begin
                        col_in_reg <= TILE_W'(col_inc);
                    end
                end
            end
        end
    end

    // Pending result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (emit_now) begin
            pend_valid_reg <= 1'b1;
        end else if (cmd.flush) begin
            pend_valid_reg <= 1'b0;
        end
        if (emit_now) begin
            pend_addr_reg <= addr_calc;
            pend_done_reg <= done_pos;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.zero_emit || ((emit_now || cmd.flush) && pend_valid_reg)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.zero_emit) begin
            m_addr_reg  <= emit_pos ? addr_calc : '0;
            m_blue_reg  <= blue_reg;
            m_green_reg <= green_reg;
            m_red_reg   <= red_reg;
            m_last_reg  <= 1'b1;
            m_err_reg   <= 1'b1;
            m_done_reg  <= 1'b0;
        end else if ((emit_now || cmd.flush) && pend_valid_reg) begin
            m_addr_reg  <= pend_addr_reg;
            m_blue_reg  <= blue_reg;
            m_green_reg <= green_reg;
            m_red_reg   <= red_reg;
            m_last_reg  <= cmd.flush;
            m_err_reg   <= run_err_reg;
            m_done_reg  <= pend_done_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_addr  = m_addr_reg;
    assign m_blue  = m_blue_reg;
    assign m_green = m_green_reg;
    assign m_red   = m_red_reg;
    assign m_last  = m_last_reg;
    assign m_err   = m_err_reg;
    assign m_done  = m_done_reg;

endmodule

@@ design/tiled_rgb_run_length_decoder.sv @@
// ----------------------------------------------------------------------------
// Tiled RGB run-length decoder
// Expands blue/green/red/length runs into pixels walked tile by tile.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Payload
// s_       in         tdata[7:0] stream byte (blue, green, red, length, ...)
// m_       out        tdata address/blue/green/red, tlast, tuser error/complete
// cfg_     in         cfg_index register number, cfg_data register value
//
// For a length byte, capped at 64, the cursor unit visits one tile position
// per cycle, positions right of the image included, and a final flush step
// releases the held last pixel. A zero length emits one error pixel. All
// control state is cleared by a synchronous low aresetn. A stalled m_
// channel pauses the walk in place.
//
`include "tiled_rgb_run_length_decoder_macros.svh"

module tiled_rgb_run_length_decoder
    import trld_pkg::*;
#(
    parameter int MAX_BLOCK = DEF_MAX_BLOCK,
    parameter int MAX_RUN   = DEF_MAX_RUN
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream: one compressed byte per request.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] stream_byte
    // Result stream: one pixel per request.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [23:0] pixel_address, [31:24] blue_value,
                                             // [39:32] green_value, [47:40] red_value
    output logic                  m_tlast,   // run_last
    output logic [OUT_USER_W-1:0] m_tuser,   // [0] run_error, [1] image_complete
    // Register write port.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DIM_W-1:0]      cfg_data
);

    trld_cmd_t           cmd;
    trld_sts_t           sts;
    logic [ADDR_W-1:0]   pix_addr;
    logic [COLOUR_W-1:0] pix_blue, pix_green, pix_red;
    logic                pix_err, pix_done;

    // Registers are always writable; the user writes them only between runs.
    assign cfg_ready = 1'b1;

    // The controller owns the byte phase and run sequencing.
    trld_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath walks the tiles, forms addresses and holds the results.
    // One pixel is kept pending so that the final pixel of a run can be
    // flagged even when the run is cut short by dropped positions or the end
    // of the image.
    trld_datapath #(
        .MAX_BLOCK (MAX_BLOCK),
        .MAX_RUN   (MAX_RUN)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_byte   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_ready   (m_tready),
        .m_valid   (m_tvalid),
        .m_addr    (pix_addr),
        .m_blue    (pix_blue),
        .m_green   (pix_green),
        .m_red     (pix_red),
        .m_last    (m_tlast),
        .m_err     (pix_err),
        .m_done    (pix_done)
    );

    assign m_tdata = {pix_red, pix_green, pix_blue, pix_addr};
    assign m_tuser = {pix_done, pix_err};

    // The final pixel of the image always closes its run.
    `TRLD_ASSERT_IMPLY(a_complete_is_last, m_tvalid && m_tuser[1], m_tlast, "complete pixel without tlast")
    // A held pixel belongs to a run in progress, so no new byte may be taken.
    `TRLD_ASSERT_IMPLY(a_pending_blocks_input, sts.pend_valid, !s_tready, "input ready with a pixel pending")
    // Nothing is presented straight after reset.
    `TRLD_ASSERT_NEXT_ALWAYS(a_reset_quiet, !aresetn, !m_tvalid, "result valid after reset")

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// Tiled RGB run-length decoder testbench
// Feeds compressed colour/length runs through the decoder under several image
// and tile geometries, with bursty input and a stalling pixel receiver, and
// compares every pixel against an in-bench tile-walk predictor.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import trld_pkg::*;

    localparam int unsigned CLK_PERIOD      = 4;
    localparam int unsigned WATCHDOG_CYCLES = 600_000;
    // Pad for a length byte whose walk, up to its capped run, emits nothing.
    localparam int unsigned LATENCY_PAD     = DEF_MAX_RUN + 16;
    localparam int unsigned LONG_HOLDOFF    = 300;
    localparam int unsigned NUM_PHASES      = 7;
    // Index beyond the register map; a write to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Position of the next stream byte within its four-byte run.
    typedef enum logic [1:0] {
        SLOT_BLUE,
        SLOT_GREEN,
        SLOT_RED,
        SLOT_LENGTH
    } stream_slot_t;

    // Behaviour of the pixel receiver between long hold-offs.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN,
        RX_SPARSE
    } rx_mode_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [COLOUR_W-1:0] blue;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] red;
        logic                last;
        logic                err;
        logic                done;
    } pixel_t;

    // Tile-walk predictor together with the queue of pixels still owed by the block.
    class tile_walk_scoreboard;
        logic [DIM_W-1:0]    width_reg  = RST_IMAGE_WIDTH;
        logic [DIM_W-1:0]    height_reg = RST_IMAGE_HEIGHT;
        logic [BLK_W-1:0]    block_reg  = RST_BLOCK_SIZE;
        stream_slot_t        slot       = SLOT_BLUE;
        logic [COLOUR_W-1:0] blue       = '0;
        logic [COLOUR_W-1:0] green      = '0;
        logic [COLOUR_W-1:0] red        = '0;
        int unsigned         tile_row   = 0;
        int unsigned         tile_col   = 0;
        int unsigned         row_in     = 0;
        int unsigned         col_in     = 0;
        bit                  filled     = 1'b0;
        pixel_t              pending_pixels[$];
        int unsigned         errors     = 0;
        int unsigned         checked    = 0;

        function int unsigned outstanding();
            return pending_pixels.size();
        endfunction

        function int unsigned clamp_to(int unsigned v, int unsigned top);
            if (v == 0) return 1;
            return (v > top) ? top : v;
        endfunction

        task report_mismatch(string what);
            errors++;
            // Keep the log readable if the block is badly broken; the count goes on.
            if (errors <= 200) $display("%0t ns: pixel %0d: %s", $time, checked, what);
        endtask

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
            case (idx)
                REG_IMAGE_WIDTH:  width_reg  = value;
                REG_IMAGE_HEIGHT: height_reg = value;
                REG_BLOCK_SIZE:   block_reg  = value[BLK_W-1:0];
                default: ;
            endcase
        endfunction

        function void step_cursor(int unsigned w, int unsigned h, int unsigned bs);
            col_in++;
            if (col_in >= bs) begin
                col_in = 0;
                row_in++;
                if (row_in >= bs) begin
                    row_in = 0;
                    tile_col += bs;
                    if (tile_col >= w) begin
                        tile_col = 0;
                        tile_row += bs;
                        if (tile_row >= h) filled = 1'b1;
                    end
                end
            end
        endfunction

        function void expand_run(logic [7:0] length_byte);
            int unsigned w, h, bs, len, r, c, i, n;
            bit          sat;
            pixel_t      px;
            w   = clamp_to(width_reg, MAX_DIMENSION);
            h   = clamp_to(height_reg, MAX_DIMENSION);
            bs  = clamp_to(block_reg, DEF_MAX_BLOCK);
            len = length_byte;
            n   = 0;
            px.blue  = blue;
            px.green = green;
            px.red   = red;
            px.done  = 1'b0;
            r = tile_row + row_in;
            c = tile_col + col_in;
            if (len == 0) begin
                // Zero length: one error pixel at the cursor, which stays put.
                px.addr = (!filled && r < h && c < w) ? ADDR_W'(r * w + c) : '0;
                px.last = 1'b1;
                px.err  = 1'b1;
                pending_pixels.push_back(px);
                return;
            end
            sat = (len > DEF_MAX_RUN);
            if (sat) len = DEF_MAX_RUN;
            px.err  = sat;
            px.last = 1'b0;
            for (i = 0; i < len && !filled; i++) begin
                r = tile_row + row_in;
                c = tile_col + col_in;
                if (r >= h) begin
                    filled = 1'b1;
                    break;
                end
                // Tile positions right of the image use up a pixel but emit nothing.
                if (c < w) begin
                    px.addr = ADDR_W'(r * w + c);
                    px.done = (r == h - 1) && (c == w - 1);
                    pending_pixels.push_back(px);
                    n++;
                    if (px.done) filled = 1'b1;
                end
                step_cursor(w, h, bs);
            end
            // A run cut short by the end of the image ends on its last emitted pixel.
            if (n > 0) pending_pixels[pending_pixels.size() - 1].last = 1'b1;
        endfunction

        function void decode_byte(logic [7:0] b);
            case (slot)
                SLOT_BLUE: begin
                    blue = b;
                    slot = SLOT_GREEN;
                end
                SLOT_GREEN: begin
                    green = b;
                    slot = SLOT_RED;
                end
                SLOT_RED: begin
                    red = b;
                    slot = SLOT_LENGTH;
                end
                default: begin
                    slot = SLOT_BLUE;
                    expand_run(b);
                end
            endcase
        endfunction

        task check_pixel(pixel_t got);
            pixel_t want;
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel at address %0d", got.addr));
                return;
            end
            want = pending_pixels.pop_front();
            if (got.addr !== want.addr)
                report_mismatch($sformatf("address %0d, expected %0d", got.addr, want.addr));
            if (got.blue !== want.blue)
                report_mismatch($sformatf("blue %h, expected %h", got.blue, want.blue));
            if (got.green !== want.green)
                report_mismatch($sformatf("green %h, expected %h", got.green, want.green));
            if (got.red !== want.red)
                report_mismatch($sformatf("red %h, expected %h", got.red, want.red));
            if (got.last !== want.last)
                report_mismatch($sformatf("run_last %b, expected %b", got.last, want.last));
            if (got.err !== want.err)
                report_mismatch($sformatf("run_error %b, expected %b", got.err, want.err));
            if (got.done !== want.done)
                report_mismatch($sformatf("image_complete %b, expected %b",
                                          got.done, want.done));
            checked++;
        endtask
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [DIM_W-1:0]      cfg_data  = '0;

    tile_walk_scoreboard walk = new();

    // Bytes waiting to be offered on the input stream.
    logic [7:0]  stream_q[$];

    // Receiver control: the stimulus raises a request count, the receiver serves it.
    rx_mode_t    rx_mode          = RX_ALWAYS;
    int unsigned holdoff_requests = 0;
    int unsigned holdoff_served   = 0;
    int unsigned holdoff_left     = 0;
    int unsigned rx_tick          = 0;

    // Geometry of each random phase. Out-of-range values check the clamping, a
    // block value above four bits checks that only the low bits are kept, and
    // the widths of 13 and 37 leave partial tiles at the right edge.
    int unsigned phase_width  [NUM_PHASES] = '{4096, 13, 24, 0, 8191, 37, 32};
    int unsigned phase_height [NUM_PHASES] = '{8191, 4096, 4096, 4096, 4096, 5000, 4096};
    int unsigned phase_block  [NUM_PHASES] = '{15, 8, 'h1003, 0, 4, 5, 8};
    int unsigned phase_runs   [NUM_PHASES] = '{14, 18, 14, 5, 16, 16, 16};
    int unsigned phase_gap    [NUM_PHASES] = '{4, 0, 6, 3, 2, 8, 1};
    rx_mode_t    phase_rx     [NUM_PHASES] = '{RX_RANDOM, RX_PATTERN, RX_ALWAYS, RX_SPARSE,
                                               RX_RANDOM, RX_PATTERN, RX_RANDOM};

    localparam int unsigned PRESSURE_PHASE = 1;  // long receiver hold-off, sender never idles
    localparam int unsigned PAUSE_PHASE    = 2;  // sender drains the block halfway through
    localparam int unsigned UNUSED_PHASE   = 3;  // also writes the unmapped register index
    localparam int unsigned SPLIT_PHASE    = 4;  // ends mid-run; the next phase finishes it

    tiled_rgb_run_length_decoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] stream_byte
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [23:0] address, [31:24] blue, [39:32] green, [47:40] red
        .m_tlast   (m_tlast),    // run_last
        .m_tuser   (m_tuser),    // [0] run_error, [1] image_complete
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2.0) aclk = ~aclk;

    // Monitor: every request on all three channels is seen at the same edge, in a
    // fixed order, before any of the edge's updates land. Register writes and
    // input bytes therefore reach the predictor before any pixel they could cause.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) walk.write_register(cfg_index, cfg_data);
            if (s_tvalid && s_tready) walk.decode_byte(s_tdata);
            if (m_tvalid && m_tready)
                walk.check_pixel('{addr:  m_tdata[23:0],  blue: m_tdata[31:24],
                                   green: m_tdata[39:32], red:  m_tdata[47:40],
                                   last:  m_tlast, err: m_tuser[0], done: m_tuser[1]});
        end
    end

    // Pixel receiver. A pending hold-off request keeps tready low for a long,
    // counted stretch; otherwise it follows the stall pattern of the phase.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (holdoff_served != holdoff_requests) begin
            holdoff_served <= holdoff_requests;
            holdoff_left   <= LONG_HOLDOFF;
            m_tready       <= 1'b0;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
            m_tready     <= 1'b0;
        end else begin
            rx_tick <= rx_tick + 1;
            case (rx_mode)
                RX_ALWAYS:  m_tready <= 1'b1;
                RX_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: m_tready <= ((rx_tick % 7) < 4);
                default:    m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Run length mix: mostly short runs, some up to the cap, some over it, and
    // an occasional zero.
    function automatic logic [7:0] pick_length();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel < 2) return 8'd0;
        if (sel < 12) return 8'($urandom_range(1, 16));
        if (sel < 16) return 8'($urandom_range(17, DEF_MAX_RUN));
        return 8'($urandom_range(DEF_MAX_RUN + 1, 255));
    endfunction

    task automatic queue_run(input logic [7:0] b, g, r, len);
        stream_q.push_back(b);
        stream_q.push_back(g);
        stream_q.push_back(r);
        stream_q.push_back(len);
    endtask

    task automatic queue_random_runs(input int unsigned count);
        repeat (count)
            queue_run(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), pick_length());
    endtask

    // Offers the queued bytes in bursts of random length. tvalid stays high
    // across a zero gap, so it is never lowered and raised in one step.
    task automatic send_stream(input int unsigned max_gap);
        int unsigned burst;
        int unsigned gap;
        while (stream_q.size() != 0) begin
            burst = $urandom_range(1, 12);
            s_tvalid <= 1'b1;
            while (burst != 0 && stream_q.size() != 0) begin
                s_tdata <= stream_q.pop_front();
                do @(posedge aclk); while (!s_tready);
                burst--;
            end
            gap = $urandom_range(0, max_gap);
            if (gap != 0 || stream_q.size() == 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Waits until every predicted pixel has been received. The count is read
    // at the falling edge so it never races the monitor.
    task automatic wait_for_pixels();
        do @(negedge aclk); while (walk.outstanding() != 0);
        @(posedge aclk);
    endtask

    // Colour bytes and runs outside the image leave nothing to wait for, so a
    // fixed pad covers a walk that may still be in progress.
    task automatic wait_until_idle();
        wait_for_pixels();
        repeat (LATENCY_PAD) @(posedge aclk);
    endtask

    // Writes width, height and block size back to back, and optionally the
    // unmapped index afterwards, whose data would corrupt any of them if decoded.
    task automatic program_image(input logic [DIM_W-1:0] w, h, blk, input bit poke_unused);
        logic [CFG_IDX_W-1:0] idx[4];
        logic [DIM_W-1:0]     val[4];
        int unsigned          n;
        int unsigned          k;
        idx = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_BLOCK_SIZE, REG_UNUSED};
        val = '{w, h, blk, 13'h1555};
        n = poke_unused ? 4 : 3;
        cfg_valid <= 1'b1;
        for (k = 0; k < n; k++) begin
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned p;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed runs under the reset geometry: darkest and brightest colours,
        // a run of exactly the cap, one just over it, a zero length, the largest
        // length byte and one with only the top bit set.
        rx_mode <= RX_RANDOM;
        queue_run(8'h00, 8'h00, 8'h00, 8'd1);
        queue_run(8'hFF, 8'hFF, 8'hFF, 8'(DEF_MAX_RUN));
        queue_run(8'hA5, 8'h5A, 8'h3C, 8'(DEF_MAX_RUN + 1));
        queue_run(8'h12, 8'h34, 8'h56, 8'd0);
        queue_run(8'hC3, 8'h81, 8'h7E, 8'd255);
        queue_run(8'h01, 8'h80, 8'hFE, 8'd128);
        send_stream(3);

        // Random phases. The cursor carries over each geometry change, so every
        // phase also checks positions left outside the new bounds. Heights stay
        // tall enough that the image cannot fill before the final phase.
        for (p = 0; p < NUM_PHASES; p++) begin
            wait_until_idle();
            program_image(DIM_W'(phase_width[p]), DIM_W'(phase_height[p]),
                          DIM_W'(phase_block[p]), p == UNUSED_PHASE);
            rx_mode <= phase_rx[p];
            if (p == PRESSURE_PHASE) holdoff_requests <= holdoff_requests + 1;
            if (p == SPLIT_PHASE + 1) begin
                // Red and length of the run whose first bytes closed the last phase.
                stream_q.push_back(8'($urandom_range(0, 255)));
                stream_q.push_back(pick_length());
            end
            if (p == PAUSE_PHASE) begin
                queue_random_runs(phase_runs[p] / 2);
                send_stream(phase_gap[p]);
                wait_for_pixels();
                queue_random_runs(phase_runs[p] - phase_runs[p] / 2);
            end else begin
                queue_random_runs(phase_runs[p]);
            end
            if (p == SPLIT_PHASE) begin
                stream_q.push_back(8'($urandom_range(0, 255)));
                stream_q.push_back(8'($urandom_range(0, 255)));
            end
            send_stream(phase_gap[p]);
        end

        // Final phase: the height is cut so that the current tile row is the last
        // one. Long runs then reach the bottom-right pixel, the run that gets
        // there is truncated, and later runs emit nothing but zero-length errors.
        wait_until_idle();
        program_image(DIM_W'(32), DIM_W'(walk.tile_row + 8), DIM_W'(8), 1'b0);
        rx_mode <= RX_RANDOM;
        repeat (6)
            queue_run(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(56, 255)));
        queue_random_runs(6);
        queue_run(8'h7F, 8'hF7, 8'h3E, 8'd0);
        send_stream(4);

        wait_for_pixels();
        repeat (LATENCY_PAD) @(posedge aclk);
        if (walk.errors == 0 && walk.outstanding() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: generous against the slowest legal run of this stimulus.
    initial begin
        #(WATCHDOG_CYCLES * CLK_PERIOD);
        $display("TB_ERROR");
        $finish;
    end

endmodule
